>>> rtl/fwpsp_pkg.sv
// Shared types and codes for the priority-tagged queue with selective pop.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fwpsp_pkg;

	localparam int PRIO_W = 8;
	localparam int FIELD_PAY_W = 32;
	localparam int OCC_W = 5;

	typedef logic [PRIO_W-1:0] prio_t;

	typedef enum logic [1:0] {
		ACT_PUSH        = 2'd0,
		ACT_POP_HEAD    = 2'd1,
		ACT_POP_EXACT   = 2'd2,
		ACT_POP_ATLEAST = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_MISS   = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic    busy;
		action_t action;
		prio_t   key;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/fwpsp_req_if.sv
// Request channel of the queue: valid/ready handshake plus the command item.
// Depends on fwpsp_pkg.
`default_nettype none

interface fwpsp_req_if import fwpsp_pkg::*;;
	logic                   valid;
	logic                   ready;
	action_t                action;
	logic [FIELD_PAY_W-1:0] entry_payload;
	prio_t                  entry_priority;
	prio_t                  match_priority;

	modport source (output valid, action, entry_payload, entry_priority, match_priority,
		input ready);
	modport sink (input valid, action, entry_payload, entry_priority, match_priority,
		output ready);
endinterface

`default_nettype wire

>>> rtl/fwpsp_rsp_if.sv
// Response channel of the queue: valid/ready handshake plus the result item.
// Depends on fwpsp_pkg.
`default_nettype none

interface fwpsp_rsp_if import fwpsp_pkg::*;;
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic [FIELD_PAY_W-1:0] out_payload;
	prio_t                  out_priority;
	logic [OCC_W-1:0]       occupancy;

	modport source (output valid, status, out_payload, out_priority, occupancy,
		input ready);
	modport sink (input valid, status, out_payload, out_priority, occupancy,
		output ready);
endinterface

`default_nettype wire

>>> rtl/fwpsp_cell.sv
// One queue slot: holds an entry, matches it against the key, and shifts
// from its younger neighbor to close a gap. Depends on fwpsp_pkg.
`default_nettype none

module fwpsp_cell import fwpsp_pkg::*; #(
	parameter int PAY_W = 32
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic             occupied,
	input  logic             push_sel,
	input  logic [PAY_W-1:0] push_payload,
	input  prio_t            push_priority,
	input  logic [PAY_W-1:0] next_payload,
	input  prio_t            next_priority,
	input  logic             found_in,
	output logic             found_out,
	output logic             take,
	output logic [PAY_W-1:0] payload_q,
	output prio_t            priority_q
);

	logic match;

	// Compare the held entry against the key
	always_comb begin
		match = 1'b0;
		unique case (cmd.action)
			ACT_PUSH:        match = 1'b0;
			ACT_POP_HEAD:    match = occupied;
			ACT_POP_EXACT:   match = occupied && (priority_q == cmd.key);
			ACT_POP_ATLEAST: match = occupied && (priority_q >= cmd.key);
			default:         match = 1'b0;
		endcase
	end

	// Oldest match wins; everything from the hit onward shifts
	assign take      = match && !found_in;
	assign found_out = found_in || match;

	// Load on push, or take the neighbor's entry once the hit lies at or above
	always_ff @(posedge clk) begin
		if (cmd.busy) begin
			if (cmd.action == ACT_PUSH) begin
				if (push_sel) begin
					payload_q  <= push_payload;
					priority_q <= push_priority;
				end
			end else if (found_out) begin
				payload_q  <= next_payload;
				priority_q <= next_priority;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/fifo_with_priority_selective_pop.sv
// Ordered queue of QUEUE_DEPTH entries, each a payload word and an 8-bit
// priority, with push at the tail and pop of the head, of the oldest entry
// with a given priority, or of the oldest entry with priority at least a key.
// Every request gives exactly one response item. For each item the
// request is registered, then the row of cells compares against the key, the
// found flag ripples from the head cell to the tail cell (its length sets the
// clock period), the gap closes and the response register loads. A new
// request is accepted in the cycle the previous response is taken, so the
// block holds one request at a time and waits while the response side stalls.
// Payloads keep their low PAYLOAD_BITS bits (at most 32). Occupancy reports
// the entry count after the operation, modulo 32.
// Depends on fwpsp_pkg, fwpsp_req_if, fwpsp_rsp_if and fwpsp_cell.
`default_nettype none

module fifo_with_priority_selective_pop import fwpsp_pkg::*; #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	fwpsp_req_if.sink  req,
	fwpsp_rsp_if.source rsp
);

	localparam int STORE_W = (PAYLOAD_BITS < FIELD_PAY_W) ? PAYLOAD_BITS : FIELD_PAY_W;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	// Registered request
	logic               busy_s1;
	action_t            action_s1;
	logic [STORE_W-1:0] pay_s1;
	prio_t              pri_s1;
	prio_t              key_s1;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;

	// Response register
	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [FIELD_PAY_W-1:0] rsp_payload_q;
	prio_t                  rsp_priority_q;
	logic [OCC_W-1:0]       rsp_occ_q;

	cell_cmd_t          cmd;
	logic [QUEUE_DEPTH-1:0] occupied;
	logic [QUEUE_DEPTH-1:0] push_sel;
	logic [QUEUE_DEPTH-1:0] take;
	logic [QUEUE_DEPTH:0]   found;
	logic [STORE_W-1:0]     cell_pay [QUEUE_DEPTH];
	prio_t                  cell_pri [QUEUE_DEPTH];

	logic                   full;
	logic                   req_fire;
	logic [STORE_W-1:0]     hit_pay;
	prio_t                  hit_pri;
	logic [FIELD_PAY_W-1:0] hit_pay_ext;
	status_t                status_d;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	// Accept when idle and the response slot is free by the next edge
	assign req.ready = !busy_s1 && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_s1 <= req.action;
			pay_s1    <= req.entry_payload[STORE_W-1:0];
			pri_s1    <= req.entry_priority;
			key_s1    <= req.match_priority;
		end
	end

	assign cmd.busy   = busy_s1;
	assign cmd.action = action_s1;
	assign cmd.key    = key_s1;

	assign found[0] = 1'b0;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	// Row of slots, head at index zero
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [STORE_W-1:0] nxt_pay;
		prio_t              nxt_pri;

		assign occupied[i] = (CNT_W'(i) < count_q);
		assign push_sel[i] = (CNT_W'(i) == count_q);

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt_pay = '0;
			assign nxt_pri = '0;
		end else begin : g_mid
			assign nxt_pay = cell_pay[i+1];
			assign nxt_pri = cell_pri[i+1];
		end

		fwpsp_cell #(
			.PAY_W(STORE_W)
		) u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.occupied     (occupied[i]),
			.push_sel     (push_sel[i]),
			.push_payload (pay_s1),
			.push_priority(pri_s1),
			.next_payload (nxt_pay),
			.next_priority(nxt_pri),
			.found_in     (found[i]),
			.found_out    (found[i+1]),
			.take         (take[i]),
			.payload_q    (cell_pay[i]),
			.priority_q   (cell_pri[i])
		);
	end

	// Gather the popped entry; at most one cell takes
	always_comb begin
		hit_pay = '0;
		hit_pri = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			hit_pay = hit_pay | ({STORE_W{take[i]}} & cell_pay[i]);
			hit_pri = hit_pri | ({PRIO_W{take[i]}} & cell_pri[i]);
		end
		hit_pay_ext = '0;
		hit_pay_ext[STORE_W-1:0] = hit_pay;
	end

	// Status and next count
	always_comb begin
		status_d = ST_MISS;
		count_d  = count_q;
		if (action_s1 == ACT_PUSH) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_PUSHED;
				count_d  = count_q + CNT_W'(1);
			end
		end else if (found[QUEUE_DEPTH]) begin
			status_d = ST_POPPED;
			count_d  = count_q - CNT_W'(1);
		end
		occ_ext = {{OCC_W{1'b0}}, count_d};
	end

	// Advance the count and load the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (busy_s1) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			rsp_status_q   <= status_d;
			rsp_payload_q  <= hit_pay_ext;
			rsp_priority_q <= hit_pri;
			rsp_occ_q      <= occ_ext[OCC_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.out_payload  = rsp_payload_q;
	assign rsp.out_priority = rsp_priority_q;
	assign rsp.occupancy    = rsp_occ_q;

endmodule

`default_nettype wire

>>> rtl/fwpsp_checker.sv
// Port-level checks for the queue, bound to the top level.
// Depends on fwpsp_pkg and fifo_with_priority_selective_pop.
`default_nettype none

module fwpsp_checker import fwpsp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input status_t                rsp_status,
	input logic [FIELD_PAY_W-1:0] rsp_payload,
	input prio_t                  rsp_priority,
	input logic [OCC_W-1:0]       rsp_occupancy
);

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_payload) && $stable(rsp_priority) && $stable(rsp_occupancy))
		else $error("response changed while stalled");

	// Each accepted request yields a response once the request and response registers load
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no response after accepted request");

	// Only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// Non-pop responses carry no entry
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_POPPED) |-> (rsp_payload == '0) && (rsp_priority == '0))
		else $error("entry fields nonzero on non-pop response");

endmodule

bind fifo_with_priority_selective_pop fwpsp_checker u_fwpsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_payload  (rsp.out_payload),
	.rsp_priority (rsp.out_priority),
	.rsp_occupancy(rsp.occupancy)
);

`default_nettype wire

>>> sim/fifo_with_priority_selective_pop_test.sv
// Testbench for the priority-tagged queue with selective pop: a shadow queue
// predicts every response item, and random pushes and pops run under idling on both sides.
// Depends on fwpsp_pkg, fwpsp_req_if, fwpsp_rsp_if and fifo_with_priority_selective_pop.
`timescale 1ns / 100ps

module fifo_with_priority_selective_pop_test;
	import fwpsp_pkg::*;

	localparam int DEPTH = 16;
	localparam int PBITS = 32;
	localparam logic [FIELD_PAY_W-1:0] PAY_MASK = {FIELD_PAY_W{1'b1}} >> (FIELD_PAY_W - PBITS);
	localparam int RANDOM_ITEMS = 1000;

	typedef struct packed {
		status_t                status;
		logic [FIELD_PAY_W-1:0] payload;
		prio_t                  prio;
		logic [OCC_W-1:0]       occ;
	} outcome_t;

	// Shadow copy of the queue and the response items still owed by the block
	class queue_shadow;
		logic [FIELD_PAY_W-1:0] payload_store[DEPTH];
		prio_t                  prio_store[DEPTH];
		int unsigned            count;
		outcome_t               expected_outcomes[$];
		int unsigned            errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// Apply one accepted request and queue its response item
		function void note_request(action_t act, logic [FIELD_PAY_W-1:0] pay, prio_t ent_prio,
			prio_t key);
			outcome_t o;
			int hit;
			hit = -1;
			o.status = ST_MISS;
			o.payload = '0;
			o.prio = '0;
			if (act == ACT_PUSH) begin
				if (count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					payload_store[count] = pay & PAY_MASK;
					prio_store[count] = ent_prio;
					count++;
					o.status = ST_PUSHED;
				end
			end else begin
				for (int i = 0; i < count; i++) begin
					if (hit < 0) begin
						case (act)
							ACT_POP_HEAD: hit = i;
							ACT_POP_EXACT: if (prio_store[i] == key) hit = i;
							default: if (prio_store[i] >= key) hit = i;
						endcase
					end
				end
				if (hit >= 0) begin
					o.status = ST_POPPED;
					o.payload = payload_store[hit];
					o.prio = prio_store[hit];
					// close the gap, keep order
					for (int i = hit; i + 1 < count; i++) begin
						payload_store[i] = payload_store[i + 1];
						prio_store[i] = prio_store[i + 1];
					end
					count--;
				end
			end
			o.occ = OCC_W'(count);
			expected_outcomes.push_back(o);
		endfunction

		// Compare one response item with the oldest expectation
		task check_response(outcome_t got);
			outcome_t want;
			if (expected_outcomes.size() == 0) begin
				report($sformatf("response item with nothing expected, status %s", got.status.name()));
			end else begin
				want = expected_outcomes.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.payload !== want.payload)
					report($sformatf("out_payload %h, want %h", got.payload, want.payload));
				if (got.prio !== want.prio)
					report($sformatf("out_priority %0d, want %0d", got.prio, want.prio));
				if (got.occ !== want.occ)
					report($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle = 1'b0;
	int   fill_bias = 50;
	queue_shadow book;

	fwpsp_req_if req_ch();
	fwpsp_rsp_if rsp_ch();

	fifo_with_priority_selective_pop #(
		.QUEUE_DEPTH(DEPTH),
		.PAYLOAD_BITS(PBITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none while no_idle is set
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Favor corner priorities so that exact matches are common
	function automatic prio_t pick_prio();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			4: return 8'd128;
			default: return prio_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Key: often one that is held in the queue right now
	function automatic prio_t pick_key();
		if (book.count > 0 && $urandom_range(0, 1) == 0)
			return book.prio_store[$urandom_range(0, book.count - 1)];
		return pick_prio();
	endfunction

	// Present one request and hold it until it is accepted
	task automatic send_item(action_t act, logic [FIELD_PAY_W-1:0] pay, prio_t ent_prio,
		prio_t key);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.entry_payload <= pay;
		req_ch.entry_priority <= ent_prio;
		req_ch.match_priority <= key;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(act, pay, ent_prio, key);
	endtask

	// Hold off the sender until every response item is back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (book.expected_outcomes.size() != 0);
	endtask

	task automatic random_item();
		action_t act;
		logic [FIELD_PAY_W-1:0] pay;
		int r;
		r = $urandom_range(0, 19);
		pay = (r == 0) ? '0 : (r == 1) ? '1 : FIELD_PAY_W'($urandom());
		if ($urandom_range(0, 99) < fill_bias) begin
			act = ACT_PUSH;
		end else begin
			case ($urandom_range(0, 2))
				0: act = ACT_POP_HEAD;
				1: act = ACT_POP_EXACT;
				default: act = ACT_POP_ATLEAST;
			endcase
		end
		send_item(act, pay, pick_prio(), pick_key());
	endtask

	// Sender: reset, directed items, then random items
	initial begin
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_PUSH;
		req_ch.entry_payload <= '0;
		req_ch.entry_priority <= '0;
		req_ch.match_priority <= '0;
		arst_n <= 1'b0;
		book = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty queue
		send_item(ACT_POP_HEAD, 32'hFFFF_FFFF, 8'd255, 8'd255);
		send_item(ACT_POP_EXACT, '0, 8'd0, 8'd0);
		send_item(ACT_POP_ATLEAST, 32'h1234_5678, 8'd9, 8'd0);
		// fill to the brim, extremes first
		send_item(ACT_PUSH, '0, 8'd0, 8'd255);
		send_item(ACT_PUSH, 32'hFFFF_FFFF, 8'd255, 8'd0);
		send_item(ACT_PUSH, 32'hA5A5_A5A5, 8'd7, 8'd7);
		send_item(ACT_PUSH, 32'h5A5A_5A5A, 8'd128, 8'd3);
		for (int i = 4; i < DEPTH; i++)
			send_item(ACT_PUSH, 32'hC0DE_0000 + i, prio_t'(i * 16 + 1), 8'd0);
		// push into a full queue is dropped
		send_item(ACT_PUSH, 32'hDEAD_BEEF, 8'd200, 8'd0);
		// exact hit in the middle, exact miss, at-least on the top key and on zero
		send_item(ACT_POP_EXACT, 32'hFFFF_FFFF, 8'd255, 8'd7);
		send_item(ACT_POP_EXACT, '0, 8'd0, 8'd99);
		send_item(ACT_POP_ATLEAST, '0, 8'd0, 8'd255);
		send_item(ACT_POP_ATLEAST, '0, 8'd0, 8'd0);
		send_item(ACT_POP_HEAD, '0, 8'd0, 8'd128);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: fill_bias = 15;
					1: fill_bias = 50;
					default: fill_bias = 85;
				endcase
			end
			no_idle = (n >= 200 && n < 300);
			if (n == 500)
				wait_drained();
			random_item();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (book.expected_outcomes.size() != 0)
			book.report($sformatf("%0d response items never came", book.expected_outcomes.size()));
		if (book.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Receiver: random stalls on ready, check every accepted item
	initial begin
		int stall_left;
		outcome_t got;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.out_payload, rsp_ch.out_priority, rsp_ch.occupancy};
				book.check_response(got);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
